@@ rtl/nht_pkg.sv @@
// Shared types and constants for the name-to-handle table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package nht_pkg;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    // Request kind, carried on the input tuser
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_RESOLVE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_WRITE,
        S_RESP
    } ctrl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic         load;      // capture the request, restart the scan
        logic         step;      // move to the next entry
        logic         rec_free;  // note current entry as free if none noted yet
        logic         take_hit;  // target the current entry for the write
        logic         write;     // write key/handle into the target entry
        logic         set_res;   // latch the pending result
        status_code_t res_code;
        logic         emit;      // move the pending result to the output register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic hit;         // current entry is valid and its name matches
        logic handle_nz;   // handle read from current entry is nonzero
        logic resolve;     // request is a resolve
        logic slot_free;   // current entry is not valid
        logic last;        // current entry is the highest-numbered one
        logic free_found;  // a free entry was noted earlier in the scan
        logic out_free;    // output register can take a result this cycle
    } dp_status_t;

endpackage

@@ rtl/name_to_handle_table_top.sv @@
// Each request scans the entries in order, with a memory read and then a name
// compare for each entry (states S_READ, S_CMP); a hit ends the scan early.
// Requests are handled one at a time; input ready returns in the cycle after
// the result is loaded into the output register, which waits on a stalled output.
// Reset (rst_n, async, active low) clears all valid bits and the control
// state; no clearing pass is needed.
`timescale 1ns / 1ps

module name_to_handle_table_top
    import nht_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [63:0] key_name, [95:64] handle_in
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] handle_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    nht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nht_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .in_handle  (s_axis_tdata[KEY_W+HANDLE_W-1:KEY_W]),
        .in_cmd     (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_handle (m_axis_tdata)
    );

endmodule

@@ rtl/nht_datapath.sv @@
// Datapath of the name-to-handle table: request registers, entry memories,
// valid bits, scan index, free-slot tracking and the output register.
// Depends on nht_pkg.
`timescale 1ns / 1ps

module nht_datapath
    import nht_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            sts,
    input  logic [KEY_W-1:0]      in_key,
    input  logic [HANDLE_W-1:0]   in_handle,
    input  logic                  in_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic [HANDLE_W-1:0]   out_handle
);

    localparam int IW = $clog2(ENTRIES);

    logic [KEY_W-1:0]    key_mem    [ENTRIES];
    logic [HANDLE_W-1:0] handle_mem [ENTRIES];

    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_W-1:0]    req_key_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic                req_cmd_reg;
    logic [IW-1:0]       scan_idx_reg;
    logic [IW-1:0]       tgt_idx_reg;
    logic                free_found_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    logic                cur_valid;

    assign cur_valid = valid_reg[scan_idx_reg];

    // Entry memories: one write port, one registered read port at the scan index
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            key_mem[tgt_idx_reg]    <= req_key_reg;
            handle_mem[tgt_idx_reg] <= req_handle_reg;
        end
        rd_key_reg    <= key_mem[scan_idx_reg];
        rd_handle_reg <= handle_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            tgt_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
                valid_reg[tgt_idx_reg] <= 1'b1;

            if (cmd.load)
                scan_idx_reg <= '0;
            else if (cmd.step)
                scan_idx_reg <= scan_idx_reg + IW'(1);

            if (cmd.load)
                free_found_reg <= 1'b0;
            else if (cmd.take_hit)
                tgt_idx_reg <= scan_idx_reg;
            else if (cmd.rec_free && !free_found_reg)
            begin
                tgt_idx_reg    <= scan_idx_reg;
                free_found_reg <= 1'b1;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_key_reg    <= in_key;
            req_handle_reg <= in_handle;
            req_cmd_reg    <= in_cmd;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            // only a successful resolve returns a handle
            res_handle_reg <= (cmd.res_code == ST_OK && req_cmd_reg == CMD_RESOLVE)
                              ? rd_handle_reg : '0;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
        end
    end

    always_comb
    begin
        sts.hit        = cur_valid && (rd_key_reg == req_key_reg);
        sts.handle_nz  = (rd_handle_reg != '0);
        sts.resolve    = (req_cmd_reg == CMD_RESOLVE);
        sts.slot_free  = !cur_valid;
        sts.last       = (scan_idx_reg == IW'(ENTRIES - 1));
        sts.free_found = free_found_reg;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;

endmodule

@@ rtl/nht_ctrl.sv @@
// Controller state machine of the name-to-handle table: walks the entries,
// picks the write target and sequences the result.
// Depends on nht_pkg.
`timescale 1ns / 1ps

module nht_ctrl
    import nht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                if (sts.hit)
                    state_next = sts.resolve ? S_RESP : S_WRITE;
                else if (sts.last)
                begin
                    if (!sts.resolve && (sts.free_found || sts.slot_free))
                        state_next = S_WRITE;
                    else
                        state_next = S_RESP;
                end
                else
                    state_next = S_READ;
            end
            S_WRITE:
                state_next = S_RESP;
            S_RESP:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.res_code = ST_OK;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_READ:
            begin
            end
            S_CMP:
            begin
                cmd.rec_free = sts.slot_free;
                if (sts.hit)
                begin
                    if (sts.resolve)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = sts.handle_nz ? ST_OK : ST_NOT_FOUND;
                    end
                    else
                        cmd.take_hit = 1'b1;
                end
                else if (sts.last)
                begin
                    if (sts.resolve)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_NOT_FOUND;
                    end
                    else if (!(sts.free_found || sts.slot_free))
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_FULL;
                    end
                end
                else
                    cmd.step = 1'b1;
            end
            S_WRITE:
            begin
                cmd.write    = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_OK;
            end
            S_RESP:
                cmd.emit = sts.out_free;
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/nht_checker.sv @@
// Port-level checks for the name-to-handle table, bound to the top level.
// Depends on nht_pkg and name_to_handle_table_top.
`timescale 1ns / 1ps

module nht_checker
    import nht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request at a time: no new transfer right after one is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A failed request returns a zero handle
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero handle on a failed request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                           m_axis_tuser == ST_NOT_FOUND))
        else $error("undefined status code");

endmodule

bind name_to_handle_table_top nht_checker u_nht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
